[hdl/acr_pkg.sv]
// Shared types, constants and codes of the ARP cache resolver.
package acr_pkg;

	localparam int TableDepth = 16;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);

	localparam int InW = 1 + 16 + 48 + 32 + 32 + 16 + 16 + 8 + 8 + 8 + 8;
	localparam int InBytesW = ((InW + 7) / 8) * 8;
	localparam int OutW = 3 + 16 + 48 + 32 + 48 + 32 + 16 + 16 + 8 + 8 + 8 + 8;
	localparam int OutBytesW = ((OutW + 7) / 8) * 8;

	localparam logic [2:0] CfgLocalIp = 3'd0;
	localparam logic [2:0] CfgLocalMac = 3'd1;
	localparam logic [2:0] CfgHardType = 3'd2;
	localparam logic [2:0] CfgProtoType = 3'd3;
	localparam logic [2:0] CfgHardSize = 3'd4;
	localparam logic [2:0] CfgProtoSize = 3'd5;

	localparam logic [2:0] KindReply = 3'd0;
	localparam logic [2:0] KindRequest = 3'd1;
	localparam logic [2:0] KindAnswer = 3'd2;
	localparam logic [2:0] KindNoEntry = 3'd3;
	localparam logic [2:0] KindFull = 3'd4;
	localparam logic [2:0] KindBadOp = 3'd5;

	localparam logic [15:0] OpRequest = 16'd1;
	localparam logic [15:0] OpReply = 16'd2;

	typedef struct packed {
		logic [7:0] client_id;
		logic [7:0] port_index;
		logic [7:0] pr_len;
		logic [7:0] hw_len;
		logic [15:0] pr_type;
		logic [15:0] hw_type;
		logic [31:0] target_ip;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [15:0] arp_op;
		logic cmd;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_port;
		logic [7:0] out_client;
		logic [7:0] out_pr_len;
		logic [7:0] out_hw_len;
		logic [15:0] out_pr_type;
		logic [15:0] out_hw_type;
		logic [31:0] out_target_ip;
		logic [47:0] out_target_mac;
		logic [31:0] out_sender_ip;
		logic [47:0] out_sender_mac;
		logic [15:0] out_op;
		logic [2:0] kind;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} acr_cmd_t;

endpackage

[hdl/acr_datapath.sv]
// Datapath: config registers, entry table, lookup and result build.
module acr_datapath (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [47:0] cfg_data,
	input  acr_pkg::in_item_t in_item,
	input  acr_pkg::acr_cmd_t ctl,
	output acr_pkg::out_item_t res,
	output logic res_has
);
	import acr_pkg::*;

	logic [31:0] local_ip_q;
	logic [47:0] local_mac_q;
	logic [15:0] hw_type_q, pr_type_q;
	logic [7:0] hw_len_q, pr_len_q;

	logic [TableDepth-1:0] valid_q, resolved_q, waiting_q;
	logic [31:0] ip_q [TableDepth];
	logic [47:0] mac_q [TableDepth];
	logic [7:0] port_q [TableDepth];
	logic [7:0] client_q [TableDepth];
	logic [CntW-1:0] fill_q;

	in_item_t it_q;
	logic hit_s1;
	logic [IdxW-1:0] idx_s1;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
			local_mac_q <= '0;
			hw_type_q <= 16'd1;
			pr_type_q <= 16'h0800;
			hw_len_q <= 8'd6;
			pr_len_q <= 8'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgLocalIp: local_ip_q <= cfg_data[31:0];
				CfgLocalMac: local_mac_q <= cfg_data;
				CfgHardType: hw_type_q <= cfg_data[15:0];
				CfgProtoType: pr_type_q <= cfg_data[15:0];
				CfgHardSize: hw_len_q <= cfg_data[7:0];
				CfgProtoSize: pr_len_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// parallel match, lowest index wins
	logic [31:0] key;
	logic m_hit;
	logic [IdxW-1:0] m_idx;
	assign key = in_item.cmd ? in_item.target_ip : in_item.sender_ip;
	always_comb begin
		m_hit = 1'b0;
		m_idx = '0;
		for (int i = TableDepth - 1; i >= 0; i--) begin
			if (valid_q[i] && ip_q[i] == key) begin
				m_hit = 1'b1;
				m_idx = IdxW'(i);
			end
		end
	end

	// capture item and match result
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			it_q <= in_item;
			hit_s1 <= m_hit;
			idx_s1 <= m_idx;
		end
	end

	// decision
	logic full;
	logic [IdxW-1:0] new_idx;
	logic do_ins, do_ref, do_pend, clr_wait;
	out_item_t r;
	logic r_has;
	assign full = (fill_q == CntW'(TableDepth));
	assign new_idx = fill_q[IdxW-1:0];

	always_comb begin
		r = '0;
		r_has = 1'b0;
		do_ins = 1'b0;
		do_ref = 1'b0;
		do_pend = 1'b0;
		clr_wait = 1'b0;
		if (it_q.cmd) begin
			r_has = 1'b1;
			if (hit_s1 && resolved_q[idx_s1]) begin
				r.kind = KindAnswer;
				r.out_target_mac = mac_q[idx_s1];
				r.out_target_ip = ip_q[idx_s1];
				r.out_client = it_q.client_id;
				r.out_port = port_q[idx_s1];
			end else if (!hit_s1 && full) begin
				r.kind = KindFull;
			end else begin
				do_pend = 1'b1;
				do_ins = !hit_s1;
				r.kind = KindRequest;
				r.out_op = OpRequest;
				r.out_sender_mac = local_mac_q;
				r.out_sender_ip = local_ip_q;
				r.out_target_ip = it_q.target_ip;
				r.out_hw_type = hw_type_q;
				r.out_pr_type = pr_type_q;
				r.out_hw_len = hw_len_q;
				r.out_pr_len = pr_len_q;
				r.out_port = it_q.port_index;
			end
		end else if (it_q.arp_op == OpRequest) begin
			if (it_q.target_ip == local_ip_q) begin
				r_has = 1'b1;
				if (!hit_s1 && full) begin
					r.kind = KindFull;
				end else begin
					do_ins = !hit_s1;
					do_ref = hit_s1;
					r.kind = KindReply;
					r.out_op = OpReply;
					r.out_sender_mac = local_mac_q;
					r.out_sender_ip = it_q.target_ip;
					r.out_target_mac = it_q.sender_mac;
					r.out_target_ip = it_q.sender_ip;
					r.out_hw_type = it_q.hw_type;
					r.out_pr_type = it_q.pr_type;
					r.out_hw_len = it_q.hw_len;
					r.out_pr_len = it_q.pr_len;
					r.out_port = it_q.port_index;
				end
			end else begin
				do_ref = hit_s1;
			end
		end else if (it_q.arp_op == OpReply) begin
			if (!hit_s1) begin
				r_has = 1'b1;
				r.kind = KindNoEntry;
			end else begin
				do_ref = 1'b1;
				if (waiting_q[idx_s1]) begin
					clr_wait = 1'b1;
					r_has = 1'b1;
					r.kind = KindAnswer;
					r.out_target_mac = it_q.sender_mac;
					r.out_target_ip = ip_q[idx_s1];
					r.out_client = client_q[idx_s1];
					r.out_port = it_q.port_index;
				end
			end
		end else begin
			r_has = 1'b1;
			r.kind = KindBadOp;
		end
	end

	assign res = r;
	assign res_has = r_has;

	// table update: flags and fill count
	logic [IdxW-1:0] widx;
	assign widx = do_ins ? new_idx : idx_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			resolved_q <= '0;
			waiting_q <= '0;
			fill_q <= '0;
		end else if (ctl.exec) begin
			if (do_ins) begin
				fill_q <= fill_q + 1'b1;
				valid_q[widx] <= 1'b1;
				resolved_q[widx] <= !it_q.cmd;
			end else if (do_ref) begin
				resolved_q[widx] <= 1'b1;
			end
			// entries inserted from packets start idle; a pending query sets waiting, an answer clears it
			if (do_ins || do_pend || clr_wait) waiting_q[widx] <= do_pend;
		end
	end

	// table update: payload
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			if (do_ins)
				ip_q[widx] <= it_q.cmd ? it_q.target_ip : it_q.sender_ip;
			if (do_ins || do_ref)
				mac_q[widx] <= (do_ins && it_q.cmd) ? 48'd0 : it_q.sender_mac;
			if (do_ins || do_ref || do_pend)
				port_q[widx] <= it_q.port_index;
			if (do_ins || do_pend)
				client_q[widx] <= do_pend ? it_q.client_id : 8'd0;
		end
	end

endmodule

[hdl/acr_ctrl.sv]
// Controller: sequences lookup, update and output handoff.
module acr_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  logic res_has,
	output acr_pkg::acr_cmd_t ctl,
	output logic out_load
);
	import acr_pkg::*;

	typedef enum logic [0:0] {ST_LOOK, ST_EXEC} state_t;
	state_t state_q;
	logic mv_q;

	// output register free or being drained
	logic out_free;
	assign out_free = !mv_q || m_tready;
	assign s_tready = (state_q == ST_LOOK);
	assign ctl.load = s_tready && s_tvalid;
	assign ctl.exec = (state_q == ST_EXEC) && out_free;
	assign out_load = ctl.exec && res_has;
	assign m_tvalid = mv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOOK;
			mv_q <= 1'b0;
		end else begin
			if (out_load) mv_q <= 1'b1;
			else if (m_tready) mv_q <= 1'b0;
			case (state_q)
				ST_LOOK: if (ctl.load) state_q <= ST_EXEC;
				ST_EXEC: if (ctl.exec) state_q <= ST_LOOK;
				default: state_q <= ST_LOOK;
			endcase
		end
	end

endmodule

[hdl/arp_cache_resolver_unit.sv]
// ARP cache resolver: top level joining controller, datapath and output register.
// Usage:
//  s_* stream carries one ARP packet (cmd 0) or client query (cmd 1) per
//  transfer; m_* stream carries at most one result per item. Config must be
//  written through cfg_we/cfg_index/cfg_data while the block is idle; the
//  block itself does not enforce it. Each item passes ST_LOOK and ST_EXEC:
//  on accept a parallel IP match over the 16-entry table is registered with
//  the item; in ST_EXEC the block updates the table and loads the output
//  register. s_tready is low in ST_EXEC, so a new item is not taken before
//  the last one is done; m_tvalid rises only after ST_EXEC has loaded it.
//  If the receiver stalls, one result waits in the output register and the
//  block completes the next item only once that register frees; s_tready
//  then stays low.
//  Reset (arst_n low) clears the table flags and fill count, restores the
//  config defaults and empties the output register. Entry payload is not
//  cleared; it is only read through valid entries.
//  The table holds 16 entries, filled in order and never evicted.
module arp_cache_resolver_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [47:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// cmd, arp_op, sender_mac, sender_ip, target_ip, hw_type, pr_type,
	// hw_len, pr_len, port_index, client_id, then zero pad
	input  logic [acr_pkg::InBytesW-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// kind, out_op, out_sender_mac, out_sender_ip, out_target_mac, out_target_ip,
	// out_hw_type, out_pr_type, out_hw_len, out_pr_len, out_client,
	// out_port, then zero pad
	output logic [acr_pkg::OutBytesW-1:0] m_tdata
);
	import acr_pkg::*;

	acr_cmd_t ctl;
	out_item_t res;
	logic res_has, out_load;
	out_item_t out_q;

	acr_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
		.res_has, .ctl, .out_load
	);

	acr_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_item(in_item_t'(s_tdata[InW-1:0])), .ctl, .res, .res_has
	);

	// output register
	always_ff @(posedge clk) begin
		if (out_load) out_q <= res;
	end

	assign m_tdata = {{(OutBytesW - OutW){1'b0}}, out_q};

endmodule

[hdl/acr_checker.sv]
// Port-level checker for the ARP cache resolver, bound to the top level.
module acr_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [acr_pkg::OutBytesW-1:0] m_tdata
);
	import acr_pkg::*;

	// an item is never accepted in two consecutive cycles
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("back to back accept");

	// a result appears only right after an item was being processed
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without item");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// kind is in range
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= KindBadOp)
		else $error("bad kind");

endmodule

bind arp_cache_resolver_unit acr_checker u_acr_checker (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
